// ===== rtl/wsw_pkg.sv =====
// Shared types and constants of the working set window unit.
package wsw_pkg;

   localparam int unsigned PAGE_W  = 16;  // width of the page field on both channels
   localparam int unsigned POS_W   = 16;  // width of the reference number
   localparam int unsigned SIZE_W  = 5;   // width of the set size field
   localparam int unsigned WSIZE_W = 5;   // width of the window size register

   localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd4;
   localparam logic [POS_W-1:0]   POS_MAX     = {POS_W{1'b1}};

   // Control from the sequencer to the sorted list.
   typedef struct packed {
      logic clear;   // empty the list
      logic insert;  // insert the incoming value unless already present
      logic pop;     // drop the head and move every entry down one place
   } list_ctrl_type;

endpackage

// ===== rtl/wsw_req_if.sv =====
// Request channel interface: one page reference per transfer.
interface wsw_req_if;
   logic                       valid;
   logic                       ready;
   logic [wsw_pkg::PAGE_W-1:0] page;

   modport source (output valid, output page, input ready);
   modport sink (input valid, input page, output ready);
endinterface

// ===== rtl/wsw_rsp_if.sv =====
// Response channel interface: one working set member per transfer.
interface wsw_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [wsw_pkg::POS_W-1:0]  position;
   logic [wsw_pkg::PAGE_W-1:0] member;
   logic [wsw_pkg::SIZE_W-1:0] set_size;
   logic                       last;

   modport source (output valid, output position, output member, output set_size,
                   output last, input ready);
   modport sink (input valid, input position, input member, input set_size,
                 input last, output ready);
endinterface

// ===== rtl/wsw_window_mem.sv =====
// Circular store of recent references: one write port, one registered read port.
module wsw_window_mem #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned DATA_W = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wsw_sort_list.sv =====
// Ascending list of distinct values, filled by parallel insertion, drained from the head.
module wsw_sort_list #(
   parameter int unsigned N      = 16,
   parameter int unsigned DATA_W = 16,
   parameter int unsigned CNT_W  = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wsw_pkg::list_ctrl_type ctrl,
   input  logic [DATA_W-1:0]      din,
   output logic [DATA_W-1:0]      head,
   output logic                   head_last,
   output logic [CNT_W-1:0]       count
);

   logic [N-1:0]      vld_ff, vld_in;
   logic [DATA_W-1:0] val_ff [N];
   logic [DATA_W-1:0] val_in [N];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [N-1:0]      below, equal;
   logic [N:0]        below_ext, vld_ext, vld_up;
   logic [DATA_W-1:0] val_ext [N+1];
   logic [DATA_W-1:0] val_up [N+1];
   logic              dup;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         below[i] = vld_ff[i] && (val_ff[i] < din);
         equal[i] = vld_ff[i] && (val_ff[i] == din);
      end
      dup       = |equal;
      // Extended views: entry i+1 is lane i, entry 0 stands for "before the head".
      below_ext = {below, 1'b1};
      vld_ext   = {vld_ff, 1'b1};
      vld_up    = {1'b0, vld_ff};
      val_ext[0] = din;
      for (int i = 0; i < N; i++) begin
         val_ext[i+1] = val_ff[i];
         val_up[i]    = val_ff[i];
      end
      val_up[N] = '0;

      vld_in = vld_ff;
      cnt_in = cnt_ff;
      for (int i = 0; i < N; i++) begin
         val_in[i] = val_ff[i];
      end

      if (ctrl.clear) begin
         vld_in = '0;
         cnt_in = '0;
      end else if (ctrl.insert && !dup) begin
         // Lanes below the new value keep theirs, the first lane above takes it,
         // and the rest move up by one place.
         for (int i = 0; i < N; i++) begin
            if (!below[i]) begin
               val_in[i] = below_ext[i] ? din : val_ext[i];
            end
         end
         vld_in = vld_ff | vld_ext[N-1:0];
         cnt_in = cnt_ff + 1'b1;
      end else if (ctrl.pop) begin
         for (int i = 0; i < N; i++) begin
            val_in[i] = val_up[i+1];
         end
         vld_in = vld_up[N:1];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         val_ff[i] <= val_in[i];
      end
   end

   assign head      = val_ff[0];
   assign head_last = !vld_up[1];
   assign count     = cnt_ff;

endmodule

// ===== rtl/working_set_window_unit.sv =====
// Top level of the working set window unit: sequencer, counters and response register.
// The first member of a set leaves after the last count references are loaded into the sorted list,
// where count = min(references seen, window); the others follow one per cycle while the receiver is ready.
// A new reference is taken only once the previous set is fully drained; the pace is set by the single
// read port of the window store and by the one-member-per-cycle drain of the sorted list.
// Reset (synchronous, active high) clears counters, the window size to 4, and the list.
module working_set_window_unit #(
   parameter int unsigned WINDOW_MAX = 16,
   parameter int unsigned PAGE_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   wsw_req_if.sink                             req_if,
   wsw_rsp_if.source                           rsp_if,
   input  logic                                csr_write_enable,
   input  logic [wsw_pkg::WSIZE_W-1:0]         csr_write_data
);

   // Slot index, fill count and the compare width used for the window clamp.
   localparam int unsigned SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int unsigned FILL_W = $clog2(WINDOW_MAX + 1);
   localparam int unsigned CMP_W  = (FILL_W > wsw_pkg::WSIZE_W) ? FILL_W : wsw_pkg::WSIZE_W;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);
   localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(WINDOW_MAX);

   // The sequencer idles for a request, loads the last count references from the
   // store into the sorted list, then drains the list into the response register.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [wsw_pkg::WSIZE_W-1:0]      wsize_ff, wsize_in;
   logic [SLOT_W-1:0]                wslot_ff, wslot_in;
   logic [FILL_W-1:0]                filled_ff, filled_in;
   logic [wsw_pkg::POS_W-1:0]        refcnt_ff, refcnt_in;
   logic [FILL_W-1:0]                count_ff, count_in;
   logic [FILL_W-1:0]                issued_ff, issued_in;
   logic [SLOT_W-1:0]                rslot_ff, rslot_in;
   logic                             rdv_ff, rdv_in;
   logic [wsw_pkg::SIZE_W-1:0]       size_ff, size_in;

   // Response register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [wsw_pkg::POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [wsw_pkg::PAGE_W-1:0]       rsp_member_ff, rsp_member_in;
   logic [wsw_pkg::SIZE_W-1:0]       rsp_size_ff, rsp_size_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             req_xfer;
   logic                             rd_en;
   logic [PAGE_BITS-1:0]             rd_data;
   logic [PAGE_BITS-1:0]             head;
   logic                             head_last;
   logic [FILL_W-1:0]                list_cnt;
   wsw_pkg::list_ctrl_type           list_ctrl;
   logic [CMP_W-1:0]                 span;
   logic [CMP_W-1:0]                 filled_ext;
   logic                             out_free;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // A zero window acts as one reference; an oversized one is held to the store depth.
   always_comb begin
      if (wsize_ff == '0) begin
         span = CMP_W'(1);
      end else if (CMP_W'(wsize_ff) > CMP_W'(WINDOW_MAX)) begin
         span = CMP_W'(WINDOW_MAX);
      end else begin
         span = CMP_W'(wsize_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      wsize_in      = csr_write_enable ? csr_write_data : wsize_ff;
      wslot_in      = wslot_ff;
      filled_in     = filled_ff;
      refcnt_in     = refcnt_ff;
      count_in      = count_ff;
      issued_in     = issued_ff;
      rslot_in      = rslot_ff;
      rdv_in        = 1'b0;
      size_in       = size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_member_in = rsp_member_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_last_in   = rsp_last_ff;
      list_ctrl     = '0;
      rd_en         = 1'b0;
      filled_ext    = CMP_W'(filled_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               // The new reference is written at this edge; the counters advance with it.
               wslot_in   = (wslot_ff == SLOT_LAST) ? '0 : wslot_ff + 1'b1;
               filled_in  = (filled_ff == FILL_MAX) ? filled_ff : filled_ff + 1'b1;
               refcnt_in  = (refcnt_ff == wsw_pkg::POS_MAX) ? refcnt_ff : refcnt_ff + 1'b1;
               filled_ext = CMP_W'(filled_in);
               count_in   = (filled_ext < span) ? filled_in : FILL_W'(span);
               issued_in  = '0;
               rslot_in   = wslot_ff;
               list_ctrl.clear = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Reads walk back from the newest slot; each word is inserted in the cycle after its read.
            if (issued_ff != count_ff) begin
               rd_en     = 1'b1;
               rdv_in    = 1'b1;
               issued_in = issued_ff + 1'b1;
               rslot_in  = (rslot_ff == '0) ? SLOT_LAST : rslot_ff - 1'b1;
            end
            list_ctrl.insert = rdv_ff;
            if ((issued_ff == count_ff) && !rdv_ff) begin
               size_in  = wsw_pkg::SIZE_W'(list_cnt);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = refcnt_ff;
               rsp_member_in = wsw_pkg::PAGE_W'(head);
               rsp_size_in   = size_ff;
               rsp_last_in   = head_last;
               list_ctrl.pop = 1'b1;
               if (head_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wsize_ff     <= wsw_pkg::WSIZE_RESET;
         wslot_ff     <= '0;
         filled_ff    <= '0;
         refcnt_ff    <= '0;
         count_ff     <= '0;
         issued_ff    <= '0;
         rslot_ff     <= '0;
         rdv_ff       <= 1'b0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wsize_ff     <= wsize_in;
         wslot_ff     <= wslot_in;
         filled_ff    <= filled_in;
         refcnt_ff    <= refcnt_in;
         count_ff     <= count_in;
         issued_ff    <= issued_in;
         rslot_ff     <= rslot_in;
         rdv_ff       <= rdv_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pos_ff    <= rsp_pos_in;
      rsp_member_ff <= rsp_member_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.position = rsp_pos_ff;
   assign rsp_if.member   = rsp_member_ff;
   assign rsp_if.set_size = rsp_size_ff;
   assign rsp_if.last     = rsp_last_ff;

   // The write of a new reference and the reads of its window never share a cycle:
   // reads start in the state after the write, so no forwarding is needed.
   wsw_window_mem #(
      .DEPTH  (WINDOW_MAX),
      .DATA_W (PAGE_BITS),
      .ADDR_W (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (wslot_ff),
      .wr_data (PAGE_BITS'(req_if.page)),
      .rd_en   (rd_en),
      .rd_addr (rslot_ff),
      .rd_data (rd_data)
   );

   wsw_sort_list #(
      .N      (WINDOW_MAX),
      .DATA_W (PAGE_BITS),
      .CNT_W  (FILL_W)
   ) u_list (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (list_ctrl),
      .din       (rd_data),
      .head      (head),
      .head_last (head_last),
      .count     (list_cnt)
   );

   // The issue counter never runs past the number of references in the window.
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issued_ff <= count_ff)
      else $error("read issue count exceeds window count");

   // The list is never empty while members are being drained.
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (list_cnt != '0))
      else $error("drain started on an empty list");

   // A new request is never taken while a store read is still in flight.
   a_no_read_in_idle: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !rdv_ff)
      else $error("store read pending while idle");

   // The final member of a set moves the sequencer back to idle.
   a_last_ends_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && head_last) |=> (state_ff == ST_IDLE))
      else $error("set did not end on its last member");

endmodule
